FILE: sv/edfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared widths, opcodes, defaults and the scan status struct.
// ----------------------------------------------------------------------------
package edfs_pkg;

	localparam int TASK_IDX_W      = 3;
	localparam int TIME_W          = 32;
	localparam int CFG_W           = 4;
	localparam int DEF_MAX_TASKS   = 8;
	localparam int DEF_VALUE_WIDTH = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic busy;   // entries still in the evaluation stages
		logic found;  // at least one candidate with work left
	} edfs_stat_t;

endpackage
`default_nettype wire

FILE: sv/edfs_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EDF entry evaluator
// Per-entry release update, absolute deadline and running minimum search,
// one task entry per cycle over three stages.
// ----------------------------------------------------------------------------
module edfs_eval #(
	parameter int IDX_W       = 3,
	parameter int VALUE_WIDTH = edfs_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clear,
	input  wire logic                          ent_valid,
	input  wire logic                          ent_loaded,
	input  wire logic [IDX_W-1:0]              ent_idx,
	input  wire logic [VALUE_WIDTH-1:0]        ent_cap,
	input  wire logic [VALUE_WIDTH-1:0]        ent_per,
	input  wire logic [VALUE_WIDTH-1:0]        ent_dl,
	input  wire logic [VALUE_WIDTH-1:0]        ent_rem,
	input  wire logic [edfs_pkg::TIME_W-1:0]   ent_nrel,
	input  wire logic [edfs_pkg::TIME_W-1:0]   now,
	output logic                               wb_en,
	output logic [IDX_W-1:0]                   wb_idx,
	output logic [VALUE_WIDTH-1:0]             wb_rem,
	output logic [edfs_pkg::TIME_W-1:0]        wb_nrel,
	output edfs_pkg::edfs_stat_t               stat,
	output logic [IDX_W-1:0]                   best_idx,
	output logic [VALUE_WIDTH-1:0]             best_rem,
	output logic [edfs_pkg::TIME_W-1:0]        best_nrel
);
	import edfs_pkg::*;

	localparam int VW = VALUE_WIDTH;

	logic              released;
	logic [TIME_W-1:0] base;

	logic              v_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [VW-1:0]     rem_s2, dl_s2, per_s2;
	logic [TIME_W-1:0] nrel_s2, base_s2;
	logic [TIME_W:0]   abs_dl;

	logic              v_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [VW-1:0]     rem_s3, per_s3;
	logic [TIME_W-1:0] nrel_s3;
	logic [TIME_W:0]   abs_s3;

	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [VW-1:0]     best_rem_q, best_per_q;
	logic [TIME_W-1:0] best_nrel_q;
	logic [TIME_W:0]   best_dl_q;
	logic              better;

	// stage 1: release check; the release time of a fresh job is its old
	// next release, otherwise next release minus period (mod 2^32)
	always_comb begin
		released = (ent_nrel == now);
		wb_rem   = released ? ent_cap : ent_rem;
		wb_nrel  = released ? ent_nrel + TIME_W'(ent_per) : ent_nrel;
		base     = released ? ent_nrel : ent_nrel - TIME_W'(ent_per);
		wb_en    = ent_valid && ent_loaded;
		wb_idx   = ent_idx;
	end

	// stage 2: absolute deadline, one bit wider than time
	assign abs_dl = {1'b0, base_s2} + (TIME_W+1)'(dl_s2);

	// stage 3: strict compare keeps the lower index on a full tie
	assign better = !found_q || (abs_s3 < best_dl_q) ||
		((abs_s3 == best_dl_q) && (per_s3 < best_per_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s2 <= ent_valid;
			v_s3 <= v_s2;
			if (clear) begin
				found_q <= 1'b0;
			end else if (v_s3 && (rem_s3 != '0) && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= ent_idx;
		rem_s2  <= wb_rem;
		nrel_s2 <= wb_nrel;
		base_s2 <= base;
		dl_s2   <= ent_dl;
		per_s2  <= ent_per;

		idx_s3  <= idx_s2;
		rem_s3  <= rem_s2;
		nrel_s3 <= nrel_s2;
		abs_s3  <= abs_dl;
		per_s3  <= per_s2;

		if (v_s3 && (rem_s3 != '0) && better && !clear) begin
			best_idx_q  <= idx_s3;
			best_rem_q  <= rem_s3;
			best_nrel_q <= nrel_s3;
			best_dl_q   <= abs_s3;
			best_per_q  <= per_s3;
		end
	end

	assign stat.busy  = v_s2 || v_s3;
	assign stat.found = found_q;
	assign best_idx   = best_idx_q;
	assign best_rem   = best_rem_q;
	assign best_nrel  = best_nrel_q;

endmodule
`default_nettype wire

FILE: sv/edf_periodic_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Load request: accepted in any idle cycle, no response.
// Tick request: one entry is read from the task memory per cycle and walks a
// three-stage evaluator. No new request until the tick ends.
// Reset clears control, time, job total and per-entry loaded bits; an entry
// never loaded reads as zero remaining work and zero next release.
// ----------------------------------------------------------------------------
// EDF periodic task scheduler
// Earliest-deadline-first pick of one task per tick over a table of periodic
// tasks, with release handling, job completion count and saturating time.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler #(
	parameter int MAX_TASKS   = edfs_pkg::DEF_MAX_TASKS,
	parameter int VALUE_WIDTH = edfs_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration: task_count
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [edfs_pkg::CFG_W-1:0]      cfg_data,
	// request channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            opcode,
	input  wire logic [edfs_pkg::TASK_IDX_W-1:0] task_index,
	input  wire logic [VALUE_WIDTH-1:0]          capacity,
	input  wire logic [VALUE_WIDTH-1:0]          period,
	input  wire logic [VALUE_WIDTH-1:0]          relative_deadline,
	// response channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [edfs_pkg::TIME_W-1:0]          tick_time,
	output logic                                 running_valid,
	output logic [edfs_pkg::TASK_IDX_W-1:0]      running_task,
	output logic                                 job_completed,
	output logic [edfs_pkg::TIME_W-1:0]          completed_jobs,
	output logic                                 time_overflow
);
	import edfs_pkg::*;

	localparam int VW     = VALUE_WIDTH;
	localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int CFGM_W = 3 * VW;          // {capacity, period, deadline}
	localparam int DYNM_W = VW + TIME_W;     // {remaining, next release}

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  task_count_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] total_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic [CNT_W-1:0]  n_next;

	// Task storage: static parameters are written only by loads, the
	// dynamic pair by loads, the release pass and the final decrement.
	logic [CFGM_W-1:0] cfg_mem [MAX_TASKS];
	logic [DYNM_W-1:0] dyn_mem [MAX_TASKS];
	logic              loaded_q [MAX_TASKS];

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [CFGM_W-1:0] cfg_s1;
	logic [DYNM_W-1:0] dyn_s1;
	logic              loaded_s1;

	logic              in_acc;
	logic              load_wr;
	logic              tick_start;
	logic [IDX_W-1:0]  load_addr;

	logic              dyn_we;
	logic [IDX_W-1:0]  dyn_waddr;
	logic [DYNM_W-1:0] dyn_wdata;

	// evaluator interface
	logic              wb_en;
	logic [IDX_W-1:0]  wb_idx;
	logic [VW-1:0]     wb_rem;
	logic [TIME_W-1:0] wb_nrel;
	edfs_stat_t        stat;
	logic [IDX_W-1:0]  best_idx;
	logic [VW-1:0]     best_rem;
	logic [TIME_W-1:0] best_nrel;

	logic [VW-1:0]     ent_cap, ent_per, ent_dl, ent_rem;
	logic [TIME_W-1:0] ent_nrel;

	logic              out_free;
	logic              fin_go;
	logic              job_done;

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign load_addr  = IDX_W'(task_index);
	// indices past the table depth are dropped
	assign load_wr    = in_acc && (opcode == OP_LOAD) && (int'(task_index) < MAX_TASKS);
	assign tick_start = in_acc && (opcode == OP_TICK);

	// active entries, capped at the table depth
	assign n_next = (int'(task_count_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
		: CNT_W'(task_count_q);

	// scan read issue: one entry per cycle
	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < n_q);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	// final step waits for the response slot
	assign out_free = !out_valid || out_ready;
	assign fin_go   = (state_q == ST_FINAL) && out_free;
	assign job_done = stat.found && (best_rem == VW'(1));

	// ------------------------------------------------------------------
	// Dynamic-pair write port: load, release pass or final decrement;
	// the three never overlap since each belongs to its own state.
	// ------------------------------------------------------------------
	always_comb begin
		dyn_we    = 1'b0;
		dyn_waddr = load_addr;
		dyn_wdata = '0;
		if (load_wr) begin
			dyn_we = 1'b1;
		end else if (wb_en) begin
			dyn_we    = 1'b1;
			dyn_waddr = wb_idx;
			dyn_wdata = {wb_rem, wb_nrel};
		end else if (fin_go && stat.found) begin
			dyn_we    = 1'b1;
			dyn_waddr = best_idx;
			dyn_wdata = {best_rem - VW'(1), best_nrel};
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			cfg_mem[load_addr] <= {capacity, period, relative_deadline};
		end
		if (dyn_we) begin
			dyn_mem[dyn_waddr] <= dyn_wdata;
		end
		if (rd_en) begin
			cfg_s1    <= cfg_mem[rd_addr];
			dyn_s1    <= dyn_mem[rd_addr];
			loaded_s1 <= loaded_q[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
	end

	// loaded bits stand in for the zero reset of the dynamic pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				loaded_q[i] <= 1'b0;
			end
		end else if (load_wr) begin
			loaded_q[load_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
		end
	end

	// unloaded entries behave as all zeros
	assign ent_cap  = loaded_s1 ? cfg_s1[3*VW-1:2*VW] : '0;
	assign ent_per  = loaded_s1 ? cfg_s1[2*VW-1:VW]   : '0;
	assign ent_dl   = loaded_s1 ? cfg_s1[VW-1:0]      : '0;
	assign ent_rem  = loaded_s1 ? dyn_s1[DYNM_W-1:TIME_W] : '0;
	assign ent_nrel = loaded_s1 ? dyn_s1[TIME_W-1:0]      : '0;

	edfs_eval #(
		.IDX_W       (IDX_W),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (tick_start),
		.ent_valid  (rd_v_s1),
		.ent_loaded (loaded_s1),
		.ent_idx    (rd_idx_s1),
		.ent_cap    (ent_cap),
		.ent_per    (ent_per),
		.ent_dl     (ent_dl),
		.ent_rem    (ent_rem),
		.ent_nrel   (ent_nrel),
		.now        (time_q),
		.wb_en      (wb_en),
		.wb_idx     (wb_idx),
		.wb_rem     (wb_rem),
		.wb_nrel    (wb_nrel),
		.stat       (stat),
		.best_idx   (best_idx),
		.best_rem   (best_rem),
		.best_nrel  (best_nrel)
	);

	// ------------------------------------------------------------------
	// Sequencer: state, counters, time, job total and response register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			task_count_q   <= '0;
			time_q         <= '0;
			total_q        <= '0;
			n_q            <= '0;
			rd_cnt_q       <= '0;
			out_valid      <= 1'b0;
			tick_time      <= '0;
			running_valid  <= 1'b0;
			running_task   <= '0;
			job_completed  <= 1'b0;
			completed_jobs <= '0;
			time_overflow  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				task_count_q <= cfg_data;
			end
			// a new response loaded in the same cycle keeps valid high
			if (out_valid && out_ready && !fin_go) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (tick_start) begin
						n_q      <= n_next;
						rd_cnt_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end else if (!rd_v_s1 && !stat.busy) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						out_valid      <= 1'b1;
						tick_time      <= time_q;
						running_valid  <= stat.found;
						running_task   <= stat.found ? TASK_IDX_W'(best_idx) : '0;
						job_completed  <= job_done;
						time_overflow  <= (time_q == '1);
						if (job_done && (total_q != '1)) begin
							total_q        <= total_q + TIME_W'(1);
							completed_jobs <= total_q + TIME_W'(1);
						end else begin
							completed_jobs <= total_q;
						end
						// time holds once it reaches all ones
						if (time_q != '1) begin
							time_q <= time_q + TIME_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
